@@ sv/box_to_circle_cover_unit_defines.svh @@
// Assertion macros shared by the box to circle cover unit.
`ifndef BOX_TO_CIRCLE_COVER_UNIT_DEFINES_SVH
`define BOX_TO_CIRCLE_COVER_UNIT_DEFINES_SVH
// Property that must hold at every clock edge outside reset.
`define BCC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication checked at every clock edge outside reset.
`define BCC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`endif

@@ sv/bcc_pkg.sv @@
// Package with the shared types and constants of the box to circle cover unit.
`default_nettype none
package bcc_pkg;
   localparam logic [15:0] NEAR_SQUARE_UNITS = 16'd10;
   localparam logic [15:0] SPACING_RESET = 16'd1024;

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [16:0] tx;
      logic signed [16:0] ty;
      logic [15:0]        big;
      logic [15:0]        rad;
      logic [17:0]        span;
      logic               single;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_STEP, ST_MUL, ST_ADD, ST_OUT
   } back_state_type;
endpackage
`default_nettype wire

@@ sv/bcc_front.sv @@
// Front end: classifies a box, picks the long axis and the radius.
`default_nettype none
module bcc_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic signed [31:0]    in_cx,
   input  wire logic signed [31:0]    in_cy,
   input  wire logic [15:0]           in_hl,
   input  wire logic [15:0]           in_hw,
   input  wire logic signed [15:0]    in_tx,
   input  wire logic signed [15:0]    in_ty,
   output logic                       job_valid,
   input  wire logic                  job_ready,
   output bcc_pkg::job_type           job
);
   bcc_pkg::job_type job_ff, job_in;
   logic valid_ff;
   logic [15:0] diff;
   logic swap;

   assign in_ready = !valid_ff || job_ready;
   assign job_valid = valid_ff;
   assign job = job_ff;

   always_comb begin
      swap = in_hl < in_hw;
      diff = swap ? in_hw - in_hl : in_hl - in_hw;
      job_in.cx = in_cx;
      job_in.cy = in_cy;
      job_in.single = diff < bcc_pkg::NEAR_SQUARE_UNITS;
      if (swap) begin
         job_in.tx = -(17'(in_ty));
         job_in.ty = 17'(in_tx);
         job_in.big = in_hw;
         job_in.rad = in_hl;
      end else begin
         job_in.tx = 17'(in_tx);
         job_in.ty = 17'(in_ty);
         job_in.big = in_hl;
         job_in.rad = in_hw;
      end
      job_in.span = {1'b0, job_in.big - job_in.rad, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         job_ff <= job_in;
      end
   end
endmodule
`default_nettype wire

@@ sv/bcc_queue.sv @@
// Two-entry queue between the front and back ends.
`default_nettype none
module bcc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_valid,
   output logic                   wr_ready,
   input  wire bcc_pkg::job_type  wr_data,
   output logic                   rd_valid,
   input  wire logic              rd_ready,
   output bcc_pkg::job_type       rd_data
);
   bcc_pkg::job_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr_valid && wr_ready) wp_ff <= !wp_ff;
         if (rd_valid && rd_ready) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
      end
      if (wr_valid && wr_ready) mem_ff[wp_ff] <= wr_data;
   end
endmodule
`default_nettype wire

@@ sv/bcc_back.sv @@
// Back end: circle count by serial division (a near-square box skips it), then one circle per step.
`default_nettype none
module bcc_back #(
   parameter int MAX_CIRCLES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [15:0]       spacing,
   input  wire logic              job_valid,
   output logic                   job_ready,
   input  wire bcc_pkg::job_type  job,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic signed [31:0]     out_x,
   output logic signed [31:0]     out_y,
   output logic [15:0]            out_rad,
   output logic [3:0]             out_idx,
   output logic                   out_last,
   output logic                   out_sat
);
   localparam int CW = $clog2(MAX_CIRCLES + 1);
   localparam int NW = 24;
   localparam int QW = 18;

   bcc_pkg::back_state_type state_ff, state_in;
   bcc_pkg::job_type job_ff;
   logic [QW-1:0] quo_ff, quo_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [NW-1:0] num_ff, num_in;
   logic [16:0]   dvs_ff, dvs_in;
   logic [4:0]    bit_ff, bit_in;
   logic          phase_ff, phase_in;
   logic [CW-1:0] n_ff, n_in, i_ff, i_in;
   logic          sat_ff, sat_in;
   logic [NW-1:0] acc_ff, acc_in;
   logic signed [35:0] px_ff, py_ff;
   logic signed [31:0] ox_ff, oy_ff;
   logic [NW-1:0] trial;
   logic [15:0]   sp1;
   logic [17:0]   along;
   logic signed [18:0] offset;

   function automatic logic signed [31:0] rq14(input logic signed [35:0] p);
      logic signed [35:0] q;
      q = p + 36'sd8192;
      return 32'(q >>> 14);
   endfunction

   assign sp1 = (spacing == 16'd0) ? 16'd1 : spacing;
   assign trial = {rem_ff[NW-2:0], num_ff[NW-1]};
   assign job_ready = state_ff == bcc_pkg::ST_IDLE;
   assign along = 18'(job_ff.rad) + quo_ff;
   assign offset = $signed(19'(along) - 19'(job_ff.big));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bcc_pkg::ST_IDLE: if (job_valid) begin
            state_in = job.single ? bcc_pkg::ST_OUT : bcc_pkg::ST_DIV;
         end
         bcc_pkg::ST_DIV: if (bit_ff == 5'd0 && phase_ff) state_in = bcc_pkg::ST_MUL;
         bcc_pkg::ST_STEP: if (bit_ff == 5'd0) state_in = bcc_pkg::ST_MUL;
         bcc_pkg::ST_MUL: state_in = bcc_pkg::ST_ADD;
         bcc_pkg::ST_ADD: state_in = bcc_pkg::ST_OUT;
         bcc_pkg::ST_OUT: if (out_ready) begin
            if (job_ff.single || i_ff == n_ff - CW'(1)) state_in = bcc_pkg::ST_IDLE;
            else state_in = bcc_pkg::ST_STEP;
         end
         default: state_in = bcc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; num_in = num_ff; dvs_in = dvs_ff;
      bit_in = bit_ff; phase_in = phase_ff; n_in = n_ff; i_in = i_ff;
      sat_in = sat_ff; acc_in = acc_ff;
      case (state_ff)
         bcc_pkg::ST_IDLE: begin
            i_in = '0; sat_in = 1'b0; phase_in = 1'b0; n_in = CW'(1);
            quo_in = '0; rem_in = '0; bit_in = 5'(NW - 1);
            num_in = NW'(job.span) + NW'(sp1) - NW'(1);
            dvs_in = {1'b0, sp1};
            acc_in = '0;
         end
         bcc_pkg::ST_DIV, bcc_pkg::ST_STEP: begin
            num_in = {num_ff[NW-2:0], 1'b0};
            if (trial >= NW'(dvs_ff)) begin
               rem_in = trial - NW'(dvs_ff);
               quo_in = {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[QW-2:0], 1'b0};
            end
            bit_in = bit_ff - 5'd1;
            if (state_ff == bcc_pkg::ST_DIV && bit_ff == 5'd0 && !phase_ff) begin
               if (quo_in + QW'(1) > QW'(MAX_CIRCLES)) begin
                  n_in = CW'(MAX_CIRCLES); sat_in = 1'b1;
               end else begin
                  n_in = CW'(quo_in + QW'(1));
               end
               phase_in = 1'b1;
               dvs_in = 17'(n_in - CW'(1));
               acc_in = NW'((n_in - CW'(1)) >> 1);
               num_in = NW'((n_in - CW'(1)) >> 1);
               rem_in = '0; quo_in = '0; bit_in = 5'(NW - 1);
            end
         end
         bcc_pkg::ST_OUT: if (out_ready) begin
            i_in = i_ff + CW'(1);
            acc_in = acc_ff + NW'(job_ff.span);
            num_in = acc_ff + NW'(job_ff.span);
            rem_in = '0; quo_in = '0; bit_in = 5'(NW - 1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; num_ff <= num_in; dvs_ff <= dvs_in;
      bit_ff <= bit_in; phase_ff <= phase_in; n_ff <= n_in; i_ff <= i_in;
      sat_ff <= sat_in; acc_ff <= acc_in;
      if (state_ff == bcc_pkg::ST_IDLE && job_valid) job_ff <= job;
      if (state_ff == bcc_pkg::ST_MUL) begin
         px_ff <= 36'(job_ff.tx) * 36'(offset);
         py_ff <= 36'(job_ff.ty) * 36'(offset);
      end
      if (state_ff == bcc_pkg::ST_ADD) begin
         ox_ff <= job_ff.cx + rq14(px_ff);
         oy_ff <= job_ff.cy + rq14(py_ff);
      end
   end

   assign out_valid = state_ff == bcc_pkg::ST_OUT;
   assign out_x = job_ff.single ? job_ff.cx : ox_ff;
   assign out_y = job_ff.single ? job_ff.cy : oy_ff;
   assign out_rad = job_ff.rad;
   assign out_idx = 4'(i_ff);
   assign out_last = job_ff.single || i_ff == n_ff - CW'(1);
   assign out_sat = !job_ff.single && sat_ff;
endmodule
`default_nettype wire

@@ sv/box_to_circle_cover_unit.sv @@
// Top level of the box to circle cover unit.
// Channel | Ports  | Word
// input   | req_*  | one box
// output  | rsp_*  | one circle
// config  | csr_*  | circle spacing
// An accepted box passes the front-end register and then the queue before the back end
// takes it. Two 24-bit serial divisions give the count and the first offset, then a
// multiply and an add state produce the first word; each further word needs another
// division, a multiply and an add. A near-square box skips the divisions and gives its
// word directly. The front end and a two-entry queue keep accepting boxes while the
// back end works or stalls, until both are full. Reset is synchronous and sets the
// spacing to 1024.
`default_nettype none
`include "box_to_circle_cover_unit_defines.svh"
module box_to_circle_cover_unit #(
   parameter int MAX_CIRCLES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [15:0]       csr_write_data,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic signed [31:0] req_center_x,
   input  wire logic signed [31:0] req_center_y,
   input  wire logic [15:0]       req_half_length,
   input  wire logic [15:0]       req_half_width,
   input  wire logic signed [15:0] req_tangent_x,
   input  wire logic signed [15:0] req_tangent_y,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic signed [31:0]     rsp_circle_x,
   output logic signed [31:0]     rsp_circle_y,
   output logic [15:0]            rsp_radius,
   output logic [3:0]             rsp_circle_index,
   output logic                   rsp_last_circle,
   output logic                   rsp_count_saturated
);
   logic [15:0] spacing_ff;
   logic f_valid, f_ready, q_valid, q_ready;
   bcc_pkg::job_type f_job, q_job;

   always_ff @(posedge clock) begin
      if (reset) spacing_ff <= bcc_pkg::SPACING_RESET;
      else if (csr_write_enable) spacing_ff <= csr_write_data;
   end

   bcc_front u_front (
      .clock, .reset, .in_valid(req_valid), .in_ready(req_ready),
      .in_cx(req_center_x), .in_cy(req_center_y), .in_hl(req_half_length),
      .in_hw(req_half_width), .in_tx(req_tangent_x), .in_ty(req_tangent_y),
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job));

   bcc_queue u_queue (
      .clock, .reset, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job));

   bcc_back #(.MAX_CIRCLES(MAX_CIRCLES)) u_back (
      .clock, .reset, .spacing(spacing_ff), .job_valid(q_valid),
      .job_ready(q_ready), .job(q_job), .out_valid(rsp_valid),
      .out_ready(rsp_ready), .out_x(rsp_circle_x), .out_y(rsp_circle_y),
      .out_rad(rsp_radius), .out_idx(rsp_circle_index),
      .out_last(rsp_last_circle), .out_sat(rsp_count_saturated));

   `BCC_ASSERT_IMPL(a_sat_not_single, clock, reset, rsp_valid && rsp_count_saturated, rsp_radius == rsp_radius && !(rsp_last_circle && rsp_circle_index == 4'd0), "saturated box gave a single circle")
   `BCC_ASSERT_IMPL(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, ##1 rsp_valid, "response dropped while stalled")
endmodule
`default_nettype wire
